FILE: rtl/srpg_pkg.sv
// ============================================================================
// srpg_pkg
// Shared types and constants of the stepper ramp pulse generator.
// ============================================================================
package srpg_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int ADDR_BITS   = IDX_BITS + 1;
    localparam int PERIOD_BITS = 16;
    localparam int STEP_BITS   = 12;
    localparam int PRESC_BITS  = 16;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [2:0] PH_STOP  = 3'd0;
    localparam logic [2:0] PH_ACCEL = 3'd1;
    localparam logic [2:0] PH_RUN   = 3'd2;
    localparam logic [2:0] PH_DECEL = 3'd3;
    localparam logic [2:0] PH_LRUN  = 3'd4;

    localparam logic [2:0] REG_PRESCALE     = 3'd0;
    localparam logic [2:0] REG_RUN_BEGIN    = 3'd1;
    localparam logic [2:0] REG_DECEL_BEGIN  = 3'd2;
    localparam logic [2:0] REG_RAMP_LENGTH  = 3'd3;
    localparam logic [2:0] REG_TABLE_CHOICE = 3'd4;

    typedef struct packed {
        logic                   pulse_level;
        logic                   step_end;
        logic                   busy_res;
        logic [STEP_BITS-1:0]   steps_done;
        logic [PERIOD_BITS-1:0] period_now;
    } result_t;

endpackage

FILE: rtl/srpg_ram.sv
// ============================================================================
// srpg_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module srpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/stepper_ramp_pulse_generator_unit.sv
// ============================================================================
// stepper_ramp_pulse_generator_unit
// Prescaled step pulse generator with a table-driven trapezoidal ramp.
// ============================================================================
// The block takes one request per clock cycle while the skid entry is empty, and
// returns one result per request in order; a two-entry output stage lets requests
// keep flowing while a result waits to be taken. A tick request advances the
// prescaler and period counter; at a period end in the accel or decel phase the
// ramp machine issues one read of the delay table RAM, whose data arrives in the
// following cycle and is forwarded straight into the period and compare used at
// the next period end. Load requests write the table; it has no clearing pass,
// and entries must be loaded before a move reads them.
module stepper_ramp_pulse_generator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          action,
    input  logic                                load_bank,
    input  logic [srpg_pkg::IDX_BITS-1:0]       load_index,
    input  logic [srpg_pkg::PERIOD_BITS-1:0]    load_value,
    input  logic                                start_mode,
    input  logic [srpg_pkg::PERIOD_BITS-1:0]    start_period,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                pulse_level,
    output logic                                step_end,
    output logic                                busy_res,
    output logic [srpg_pkg::STEP_BITS-1:0]      steps_done,
    output logic [srpg_pkg::PERIOD_BITS-1:0]    period_now,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srpg_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [srpg_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [srpg_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready
);

    import srpg_pkg::*;

    localparam int PROD_BITS = 2 * PERIOD_BITS + 2;
    localparam logic [PERIOD_BITS:0] RECIP3 =
        (PERIOD_BITS + 1)'(((64'd1 << (PERIOD_BITS + 1)) + 64'd2) / 64'd3);
    localparam int DIFF_BITS = STEP_BITS + 2;

    logic [PRESC_BITS-1:0]  prescale_reg;
    logic [STEP_BITS-1:0]   run_begin_reg;
    logic [STEP_BITS-1:0]   decel_begin_reg;
    logic [STEP_BITS-1:0]   ramp_length_reg;
    logic                   table_choice_reg;

    logic [PRESC_BITS-1:0]  prescale_count_reg, prescale_count_next;
    logic [PERIOD_BITS-1:0] period_count_reg, period_count_next;
    logic [PERIOD_BITS-1:0] period_active_reg, period_active_next;
    logic [PERIOD_BITS-1:0] period_shadow_reg, period_shadow_next;
    logic [PERIOD_BITS-1:0] compare_active_reg, compare_active_next;
    logic [PERIOD_BITS-1:0] compare_shadow_reg, compare_shadow_next;
    logic [STEP_BITS-1:0]   step_total_reg, step_total_next;
    logic [2:0]             phase_reg, phase_next;
    logic                   running_reg, running_next;
    logic                   pend_reg, pend_next;

    result_t                out_reg;
    result_t                skid_reg;
    result_t                res;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;

    logic                   in_fire;
    logic                   cfg_write;
    logic [2:0]             cfg_index;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic                   ram_re;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [PERIOD_BITS-1:0] ram_rdata;

    logic [PERIOD_BITS-1:0] shadow_eff;
    logic [PERIOD_BITS-1:0] compare_eff;
    logic [PROD_BITS-1:0]   third_prod;
    logic [PERIOD_BITS-1:0] third;
    logic [STEP_BITS-1:0]   step_inc;
    logic                   at_end;
    logic signed [DIFF_BITS-1:0] mirror_diff;
    logic [IDX_BITS-1:0]    accel_idx;
    logic [IDX_BITS-1:0]    mirror_idx;
    logic                   step_end_now;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[PADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg     <= '0;
            run_begin_reg    <= '0;
            decel_begin_reg  <= '0;
            ramp_length_reg  <= STEP_BITS'(1);
            table_choice_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRESCALE:     prescale_reg     <= pwdata[PRESC_BITS-1:0];
                REG_RUN_BEGIN:    run_begin_reg    <= pwdata[STEP_BITS-1:0];
                REG_DECEL_BEGIN:  decel_begin_reg  <= pwdata[STEP_BITS-1:0];
                REG_RAMP_LENGTH:  ramp_length_reg  <= pwdata[STEP_BITS-1:0];
                REG_TABLE_CHOICE: table_choice_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_PRESCALE:     prdata = PDATA_BITS'(prescale_reg);
            REG_RUN_BEGIN:    prdata = PDATA_BITS'(run_begin_reg);
            REG_DECEL_BEGIN:  prdata = PDATA_BITS'(decel_begin_reg);
            REG_RAMP_LENGTH:  prdata = PDATA_BITS'(ramp_length_reg);
            REG_TABLE_CHOICE: prdata = PDATA_BITS'(table_choice_reg);
            default:          prdata = '0;
        endcase
    end

    srpg_ram #(
        .WIDTH (PERIOD_BITS),
        .DEPTH (2 * TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (load_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr   = {load_bank, load_index};
    assign shadow_eff  = pend_reg ? ram_rdata : period_shadow_reg;
    assign compare_eff = pend_reg ? (ram_rdata >> 1) : compare_shadow_reg;

    assign third_prod = PROD_BITS'(start_period) * PROD_BITS'(RECIP3);
    assign third      = third_prod[2*PERIOD_BITS:PERIOD_BITS+1];

    assign step_inc    = step_total_reg + STEP_BITS'(1);
    assign at_end      = ({1'b0, step_inc} + (STEP_BITS + 1)'(1)) >= {1'b0, ramp_length_reg};
    assign mirror_diff = DIFF_BITS'(ramp_length_reg) - DIFF_BITS'(step_inc) - DIFF_BITS'(1);
    assign accel_idx   = (32'(step_inc) >= TABLE_DEPTH) ? IDX_BITS'(TABLE_DEPTH - 1)
                                                       : IDX_BITS'(step_inc);

    always_comb
    begin
        if (mirror_diff < 0)
        begin
            mirror_idx = '0;
        end
        else if (32'(mirror_diff) >= TABLE_DEPTH)
        begin
            mirror_idx = IDX_BITS'(TABLE_DEPTH - 1);
        end
        else
        begin
            mirror_idx = IDX_BITS'(mirror_diff);
        end
    end

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        period_count_next   = period_count_reg;
        period_active_next  = period_active_reg;
        period_shadow_next  = shadow_eff;
        compare_active_next = compare_active_reg;
        compare_shadow_next = compare_eff;
        step_total_next     = step_total_reg;
        phase_next          = phase_reg;
        running_next        = running_reg;
        pend_next           = 1'b0;
        step_end_now        = 1'b0;
        ram_we              = 1'b0;
        ram_re              = 1'b0;
        ram_raddr           = {table_choice_reg, accel_idx};

        if (in_fire)
        begin
            unique case (action)
                ACT_TICK:
                begin
                    if (running_reg)
                    begin
                        if (prescale_count_reg >= prescale_reg)
                        begin
                            prescale_count_next = '0;
                            if (period_count_reg >= period_active_reg)
                            begin
                                period_count_next   = '0;
                                period_active_next  = shadow_eff;
                                compare_active_next = compare_eff;
                                step_end_now        = 1'b1;
                                step_total_next     = step_inc;
                                unique case (phase_reg)
                                    PH_ACCEL:
                                    begin
                                        if (step_inc >= run_begin_reg)
                                        begin
                                            phase_next = PH_RUN;
                                        end
                                        ram_re    = 1'b1;
                                        ram_raddr = {table_choice_reg, accel_idx};
                                        pend_next = 1'b1;
                                    end
                                    PH_RUN:
                                    begin
                                        if (step_inc >= decel_begin_reg)
                                        begin
                                            phase_next = PH_DECEL;
                                        end
                                    end
                                    PH_DECEL:
                                    begin
                                        if (at_end)
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                        ram_re    = 1'b1;
                                        ram_raddr = {table_choice_reg, mirror_idx};
                                        pend_next = 1'b1;
                                    end
                                    PH_LRUN:
                                    begin
                                        if (at_end)
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                    end
                                    default:
                                    begin
                                        step_total_next = '0;
                                        running_next    = 1'b0;
                                    end
                                endcase
                            end
                            else
                            begin
                                period_count_next = period_count_reg + PERIOD_BITS'(1);
                            end
                        end
                        else
                        begin
                            prescale_count_next = prescale_count_reg + PRESC_BITS'(1);
                        end
                    end
                end
                ACT_LOAD:
                begin
                    ram_we = (32'(load_index) < TABLE_DEPTH);
                end
                ACT_START:
                begin
                    period_active_next  = start_period;
                    period_shadow_next  = start_period;
                    compare_active_next = third;
                    compare_shadow_next = third;
                    prescale_count_next = '0;
                    period_count_next   = '0;
                    step_total_next     = '0;
                    phase_next          = start_mode ? PH_LRUN : PH_ACCEL;
                    running_next        = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.pulse_level = !(running_next && (period_count_next < compare_active_next));
        res.step_end    = step_end_now;
        res.busy_res    = running_next;
        res.steps_done  = step_total_next;
        res.period_now  = period_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
            period_active_reg  <= '0;
            period_shadow_reg  <= '0;
            compare_active_reg <= '0;
            compare_shadow_reg <= '0;
            step_total_reg     <= '0;
            phase_reg          <= PH_STOP;
            running_reg        <= 1'b0;
            pend_reg           <= 1'b0;
        end
        else
        begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= period_count_next;
            period_active_reg  <= period_active_next;
            period_shadow_reg  <= period_shadow_next;
            compare_active_reg <= compare_active_next;
            compare_shadow_reg <= compare_shadow_next;
            step_total_reg     <= step_total_next;
            phase_reg          <= phase_next;
            running_reg        <= running_next;
            pend_reg           <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pulse_level = out_reg.pulse_level;
    assign step_end    = out_reg.step_end;
    assign busy_res    = out_reg.busy_res;
    assign steps_done  = out_reg.steps_done;
    assign period_now  = out_reg.period_now;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held without a result in the output stage.");

    a_pend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(ram_re))
        else $error("Table data forwarded without a read in the previous cycle.");

    a_idle_pin_high: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.busy_res) |-> out_reg.pulse_level)
        else $error("Step pin driven low while no move is running.");

    a_count_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        period_count_reg <= period_active_reg)
        else $error("Period counter passed the active period.");

endmodule
